// ===== rtl/core/tsu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Token scanner package
// Shared constants, token kinds and the token record of the token scanner.
// ---------------------------------------------------------------------------
package tsu_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned OFFS_W      = 16;
  localparam int unsigned LEN_W       = 16;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    KIND_NAME   = 4'd0,
    KIND_INT    = 4'd1,
    KIND_LPAREN = 4'd2,
    KIND_RPAREN = 4'd3,
    KIND_LBRACE = 4'd4,
    KIND_RBRACE = 4'd5,
    KIND_STMT   = 4'd6,
    KIND_EOF    = 4'd7,
    KIND_ERROR  = 4'd8
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [OFFS_W-1:0] start_offset;
    logic [LEN_W-1:0]  length;
    logic              last_of_run;
  } tok_t;

  // Maps a wrapped position onto the 16-bit offset field of a token.
  function automatic logic [OFFS_W-1:0] to_offs(input logic [OFFSET_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[OFFS_W-1:0];
  endfunction

endpackage

// ===== rtl/core/tsu_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Token scanner channels
// Byte input channel and token output channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;

  modport source (output valid, output byte_req, input ready);
  modport sink (input valid, input byte_req, output ready);
endinterface

interface tsu_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [15:0] start_offset;
  logic [15:0] length;
  logic        last_of_run;

  modport source (output valid, output kind, output start_offset, output length,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input start_offset, input length,
                input last_of_run, output ready);
endinterface

// ===== rtl/core/token_scanner_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Token scanner unit
// Byte-serial lexer that turns source bytes into kind, offset and length.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload
//  byte_i    in         byte_req
//  tok_o     out        kind, start_offset, length, last_of_run
//
// One byte is taken per cycle while byte_i.ready is high; its tokens enter
// a four-entry queue in the same cycle and leave it one per cycle unless
// stalled, so a byte ending a name or number that emits a token pushes two.
// byte_i.ready is low while the queue holds more than two tokens.
// Reset clears the position, the scan mode and the queue; there is no sweep.
module token_scanner_unit
  import tsu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  tsu_byte_if.sink byte_i,
  tsu_tok_if.source tok_o
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NAME = 2'd1;
  localparam logic [1:0] MODE_INT  = 2'd2;
  localparam logic [1:0] MODE_CR   = 2'd3;

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [1:0]             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LEN_W-1:0]       len_q, len_d;

  tok_t       fifo_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  logic       in_fire, out_fire;
  logic [7:0] b;
  logic       is_lower, is_digit;
  logic       close_vld, fresh_run, fresh_vld;
  tok_t       close_tok, fresh_tok, slot0, slot1;
  logic [1:0] push_n;

  assign in_fire  = byte_i.valid && byte_i.ready;
  assign out_fire = tok_o.valid && tok_o.ready;
  assign b        = byte_i.byte_req;
  assign is_lower = (b >= CH_A_LO) && (b <= CH_Z_LO);
  assign is_digit = (b >= CH_0) && (b <= CH_9);

  always_comb begin
    pos_d     = pos_q;
    mode_d    = mode_q;
    start_d   = start_q;
    len_d     = len_q;
    close_vld = 1'b0;
    close_tok = '{kind: KIND_ERROR, start_offset: to_offs(start_q), length: len_q,
                  last_of_run: 1'b0};
    fresh_run = 1'b0;
    fresh_vld = 1'b0;
    fresh_tok = '{kind: KIND_ERROR, start_offset: to_offs(pos_q), length: LEN_W'(1),
                  last_of_run: 1'b1};
    if (in_fire) begin
      pos_d = pos_q + OFFSET_BITS'(1);
      case (mode_q)
        MODE_NAME: begin
          if (is_lower || is_digit) begin
            if (len_q != LEN_MAX) len_d = len_q + LEN_W'(1);
          end else begin
            close_vld      = 1'b1;
            close_tok.kind = KIND_NAME;
            mode_d         = MODE_IDLE;
            fresh_run      = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit) begin
            if (len_q != LEN_MAX) len_d = len_q + LEN_W'(1);
          end else begin
            close_vld      = 1'b1;
            close_tok.kind = KIND_INT;
            mode_d         = MODE_IDLE;
            fresh_run      = 1'b1;
          end
        end
        MODE_CR: begin
          close_vld        = 1'b1;
          close_tok.length = LEN_W'(1);
          mode_d           = MODE_IDLE;
          if (b == CH_LF) begin
            close_tok.kind   = KIND_STMT;
            close_tok.length = LEN_W'(2);
          end else begin
            close_tok.kind = KIND_ERROR;
            fresh_run      = 1'b1;
          end
        end
        default: begin
          fresh_run = 1'b1;
        end
      endcase

      if (fresh_run) begin
        case (b) inside
          [CH_A_LO:CH_Z_LO]: begin
            mode_d  = MODE_NAME;
            start_d = pos_q;
            len_d   = LEN_W'(1);
          end
          [CH_0:CH_9]: begin
            mode_d  = MODE_INT;
            start_d = pos_q;
            len_d   = LEN_W'(1);
          end
          CH_CR: begin
            mode_d  = MODE_CR;
            start_d = pos_q;
            len_d   = LEN_W'(1);
          end
          CH_SPACE, CH_TAB: begin
            fresh_vld = 1'b0;
          end
          CH_LPAR: begin
            fresh_vld      = 1'b1;
            fresh_tok.kind = KIND_LPAREN;
          end
          CH_RPAR: begin
            fresh_vld      = 1'b1;
            fresh_tok.kind = KIND_RPAREN;
          end
          CH_LBRC: begin
            fresh_vld      = 1'b1;
            fresh_tok.kind = KIND_LBRACE;
          end
          CH_RBRC: begin
            fresh_vld      = 1'b1;
            fresh_tok.kind = KIND_RBRACE;
          end
          CH_LF: begin
            fresh_vld      = 1'b1;
            fresh_tok.kind = KIND_STMT;
          end
          CH_NUL: begin
            fresh_vld      = 1'b1;
            fresh_tok.kind = KIND_EOF;
          end
          default: begin
            fresh_vld      = 1'b1;
            fresh_tok.kind = KIND_ERROR;
          end
        endcase
      end
    end
  end

  always_comb begin
    slot0 = close_vld ? close_tok : fresh_tok;
    slot0.last_of_run = !(close_vld && fresh_vld);
    slot1 = fresh_tok;
    push_n = 2'(close_vld) + 2'(fresh_vld);
  end

  assign byte_i.ready      = (count_q <= 3'd2);
  assign tok_o.valid       = (count_q != 3'd0);
  assign tok_o.kind        = fifo_q[rd_ptr_q].kind;
  assign tok_o.start_offset = fifo_q[rd_ptr_q].start_offset;
  assign tok_o.length      = fifo_q[rd_ptr_q].length;
  assign tok_o.last_of_run = fifo_q[rd_ptr_q].last_of_run;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wr_ptr_q] <= slot0;
    if (push_n == 2'd2) fifo_q[wr_ptr_q + 2'd1] <= slot1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      mode_q   <= MODE_IDLE;
      start_q  <= '0;
      len_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      pos_q    <= pos_d;
      mode_q   <= mode_d;
      start_q  <= start_d;
      len_q    <= len_d;
      wr_ptr_q <= wr_ptr_q + push_n;
      rd_ptr_q <= rd_ptr_q + 2'(out_fire);
      count_q  <= count_q + 3'(push_n) - 3'(out_fire);
    end
  end

endmodule

// ===== rtl/core/tsu_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Token scanner checker
// Port-level assertions on the token output of the token scanner unit.
// ---------------------------------------------------------------------------
module tsu_checker
  import tsu_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tok_valid_i,
  input logic        tok_ready_i,
  input logic [3:0]  tok_kind_i,
  input logic [15:0] tok_length_i,
  input logic        tok_last_i
);

  // A stalled transaction keeps its kind, length and last_of_run.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_ready_i |=> tok_valid_i && $stable(tok_kind_i)
      && $stable(tok_length_i) && $stable(tok_last_i))
    else $error("token changed while stalled");

  // Every token covers at least one byte.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i |-> tok_length_i != 16'd0)
    else $error("token of zero length");

  // Only a closed name, number or lone CR can be followed by a second token.
  a_first_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_last_i |-> tok_kind_i == KIND_NAME
      || tok_kind_i == KIND_INT || tok_kind_i == KIND_ERROR)
    else $error("unexpected kind on first token of a pair");

  // The second token of a pair is queued together with the first.
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_ready_i && !tok_last_i |=> tok_valid_i)
    else $error("second token of a pair missing");

endmodule

bind token_scanner_unit tsu_checker u_tsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tok_valid_i  (tok_o.valid),
  .tok_ready_i  (tok_o.ready),
  .tok_kind_i   (tok_o.kind),
  .tok_length_i (tok_o.length),
  .tok_last_i   (tok_o.last_of_run)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Token scanner unit testbench
// Feeds source bytes into the scanner and compares every emitted token with
// the token predicted by a byte-serial lexer model kept inside the bench.
// Runs a directed byte sequence, a long name, random source text with noise,
// a long output stall, and a quiet tail.
// ---------------------------------------------------------------------------
module testbench;
  import tsu_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_NAME = 2'd1,
    SCAN_INT  = 2'd2,
    SCAN_CR   = 2'd3
  } scan_mode_e;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;

  tsu_byte_if byte_if ();
  tsu_tok_if  tok_if ();

  token_scanner_unit u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .byte_i(byte_if),
    .tok_o (tok_if)
  );

  logic [OFFSET_BITS-1:0] scan_pos;
  scan_mode_e             scan_mode;
  logic [OFFSET_BITS-1:0] tok_first;
  logic [LEN_W-1:0]       tok_len;
  tok_t                   expected_tokens[$];

  int  error_count;
  int  cycle_count;
  int  content_bytes;
  bit  quiet;
  int  hold_request;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_lower(logic [7:0] b);
    return b >= CH_A_LO && b <= CH_Z_LO;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic void emit_token(kind_e k, logic [OFFSET_BITS-1:0] at,
                                     logic [LEN_W-1:0] len);
    tok_t t;
    t.kind         = k;
    t.start_offset = OFFS_W'(at);
    t.length       = len;
    t.last_of_run  = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void scan_from_idle(logic [7:0] b, logic [OFFSET_BITS-1:0] at);
    if (is_lower(b)) begin
      scan_mode = SCAN_NAME;
      tok_first = at;
      tok_len   = 1;
    end else if (is_digit(b)) begin
      scan_mode = SCAN_INT;
      tok_first = at;
      tok_len   = 1;
    end else begin
      case (b)
        CH_LPAR: begin
          emit_token(KIND_LPAREN, at, 1);
        end
        CH_RPAR: begin
          emit_token(KIND_RPAREN, at, 1);
        end
        CH_LBRC: begin
          emit_token(KIND_LBRACE, at, 1);
        end
        CH_RBRC: begin
          emit_token(KIND_RBRACE, at, 1);
        end
        CH_LF: begin
          emit_token(KIND_STMT, at, 1);
        end
        CH_CR: begin
          scan_mode = SCAN_CR;
          tok_first = at;
          tok_len   = 1;
        end
        CH_NUL: begin
          emit_token(KIND_EOF, at, 1);
        end
        CH_SPACE, CH_TAB: begin
        end
        default: begin
          emit_token(KIND_ERROR, at, 1);
        end
      endcase
    end
  endfunction

  function automatic void predict_tokens(logic [7:0] b);
    logic [OFFSET_BITS-1:0] at;
    int                     queued_at_start;
    at              = scan_pos;
    queued_at_start = expected_tokens.size();
    scan_pos        = at + 1'b1;
    case (scan_mode)
      SCAN_NAME: begin
        if (is_lower(b) || is_digit(b)) begin
          if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
        end else begin
          emit_token(KIND_NAME, tok_first, tok_len);
          scan_mode = SCAN_IDLE;
          scan_from_idle(b, at);
        end
      end
      SCAN_INT: begin
        if (is_digit(b)) begin
          if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
        end else begin
          emit_token(KIND_INT, tok_first, tok_len);
          scan_mode = SCAN_IDLE;
          scan_from_idle(b, at);
        end
      end
      SCAN_CR: begin
        scan_mode = SCAN_IDLE;
        if (b == CH_LF) begin
          emit_token(KIND_STMT, tok_first, 2);
        end else begin
          emit_token(KIND_ERROR, tok_first, 1);
          scan_from_idle(b, at);
        end
      end
      default: begin
        scan_from_idle(b, at);
      end
    endcase
    if (expected_tokens.size() > queued_at_start) begin
      expected_tokens[expected_tokens.size()-1].last_of_run = 1'b1;
    end
  endfunction

  // Prediction runs before the check; a token shows on the output only in the
  // cycle after its byte, so its expectation is already queued.
  always @(posedge clk) begin
    tok_t want;
    if (rst_n) begin
      if (byte_if.valid && byte_if.ready) predict_tokens(byte_if.byte_req);
      if (tok_if.valid && tok_if.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token transaction: kind %0d start_offset %0d length %0d",
                 tok_if.kind, tok_if.start_offset, tok_if.length);
          error_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (tok_if.kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, tok_if.kind);
            error_count++;
          end
          if (tok_if.start_offset !== want.start_offset) begin
            $error("start_offset mismatch: expected %0d, actual %0d",
                   want.start_offset, tok_if.start_offset);
            error_count++;
          end
          if (tok_if.length !== want.length) begin
            $error("length mismatch: expected %0d, actual %0d", want.length, tok_if.length);
            error_count++;
          end
          if (tok_if.last_of_run !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0d, actual %0d",
                   want.last_of_run, tok_if.last_of_run);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Token receiver: random short stalls, or one long stall on request.
  initial begin
    tok_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        tok_if.ready = 1'b0;
        stall_left--;
      end else begin
        tok_if.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      byte_if.valid    = 1'b0;
      byte_if.byte_req = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    byte_if.valid    = 1'b1;
    byte_if.byte_req = b;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    if (b != CH_SPACE && b != CH_TAB) content_bytes++;
  endtask

  task automatic release_input();
    @(negedge clk);
    byte_if.valid = 1'b0;
  endtask

  task automatic wait_drain();
    release_input();
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] any_lower();
    return CH_A_LO + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_bracket();
    logic [7:0] choice[4];
    choice = '{CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC};
    return choice[$urandom_range(0, 3)];
  endfunction

  // One random piece of source text: mostly well-formed tokens, some noise.
  task automatic send_piece();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_byte(any_lower());
      n = $urandom_range(0, 6);
      repeat (n) send_byte($urandom_range(0, 2) == 0 ? any_digit() : any_lower());
    end else if (pick < 48) begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(any_digit());
    end else if (pick < 64) begin
      send_byte(any_bracket());
    end else if (pick < 72) begin
      send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end else if (pick < 82) begin
      if ($urandom_range(0, 1)) send_byte(CH_CR);
      send_byte(CH_LF);
    end else if (pick < 86) begin
      send_byte(CH_NUL);
    end else if (pick < 94) begin
      send_byte(8'($urandom));
    end else begin
      send_byte(CH_CR);
      send_byte($urandom_range(0, 1) ? CH_CR : 8'($urandom));
    end
  endtask

  task automatic run_random(input int n_bytes);
    int target;
    target = content_bytes + n_bytes;
    while (content_bytes < target) send_piece();
  endtask

  task automatic test_directed_bytes();
    logic [7:0] seq[$];
    seq = '{8'h7a, CH_0, CH_RPAR, CH_9, CH_A_LO, CH_LBRC, 8'h35, CH_SPACE, CH_TAB,
            CH_RBRC, CH_LF, CH_CR, CH_LF, CH_CR, 8'h71, CH_CR, CH_CR, CH_LF, 8'hff,
            8'h37, CH_NUL, CH_NUL, 8'h80, CH_CR, CH_NUL};
    foreach (seq[i]) send_byte(seq[i]);
    wait_drain();
  endtask

  // A long name of mixed letters and digits, closed by a bracket.
  task automatic test_long_name();
    quiet = 1'b1;
    send_byte(8'h6b);
    repeat (30) send_byte($urandom_range(0, 1) ? any_digit() : any_lower());
    send_byte(CH_LPAR);
    wait_drain();
    quiet = 1'b0;
  endtask

  task automatic test_random_source();
    run_random(300);
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    int n;
    hold_request = 60;
    for (n = 0; n < 30; n++) begin
      if (n % 5 == 0) send_byte(any_lower());
      send_byte(any_bracket());
    end
    wait_drain();
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    run_random(140);
    wait_drain();
  endtask

  initial begin
    error_count      = 0;
    cycle_count      = 0;
    content_bytes    = 0;
    quiet            = 1'b0;
    hold_request     = 0;
    stall_left       = 0;
    scan_pos         = '0;
    scan_mode        = SCAN_IDLE;
    tok_first        = '0;
    tok_len          = '0;
    byte_if.valid    = 1'b0;
    byte_if.byte_req = 8'h00;
    rst_n            = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_bytes();
    test_long_name();
    test_random_source();
    test_output_backpressure();
    test_quiet_tail();

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
